>>> rtl/assert_macros.svh
// assertion helpers, included by rtl/rational_add_reduce_unit.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/rar_pkg.sv
`timescale 1ns / 1ps

package rar_pkg;

	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_AB,
		ST_MUL_BA,
		ST_MUL_DD,
		ST_SUM,
		ST_GCD_TWO,
		ST_GCD_ODD,
		ST_SCALE,
		ST_DIV,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		MUL_AN_BD,
		MUL_BN_AD,
		MUL_AD_BD
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     form_sum;
		logic     gcd_two;
		logic     gcd_odd;
		logic     scale;
		logic     div_step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic sum_zero;
		logic both_even;
		logic gcd_eq;
		logic div_last;
	} status_t;

endpackage

>>> rtl/rar_ctrl.sv
`timescale 1ns / 1ps

module rar_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  rar_pkg::status_t  status,
	output rar_pkg::cmd_t     cmd
);

	rar_pkg::state_t state_q;
	rar_pkg::state_t state_next;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rar_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		cmd.mul_sel = rar_pkg::MUL_AN_BD;
		case (state_q)
			rar_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = rar_pkg::ST_MUL_AB;
				end
			end
			rar_pkg::ST_MUL_AB: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rar_pkg::MUL_AN_BD;
				state_next  = rar_pkg::ST_MUL_BA;
			end
			rar_pkg::ST_MUL_BA: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rar_pkg::MUL_BN_AD;
				state_next  = rar_pkg::ST_MUL_DD;
			end
			rar_pkg::ST_MUL_DD: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = rar_pkg::MUL_AD_BD;
				state_next  = rar_pkg::ST_SUM;
			end
			rar_pkg::ST_SUM: begin
				cmd.form_sum = 1'b1;
				state_next   = rar_pkg::ST_GCD_TWO;
			end
			rar_pkg::ST_GCD_TWO: begin
				// zero sum skips the reduction and leaves as 0/1
				if (status.sum_zero) begin
					state_next = rar_pkg::ST_WRITE;
				end else if (status.both_even) begin
					cmd.gcd_two = 1'b1;
				end else begin
					state_next = rar_pkg::ST_GCD_ODD;
				end
			end
			rar_pkg::ST_GCD_ODD: begin
				if (status.gcd_eq) begin
					state_next = rar_pkg::ST_SCALE;
				end else begin
					cmd.gcd_odd = 1'b1;
				end
			end
			rar_pkg::ST_SCALE: begin
				cmd.scale  = 1'b1;
				state_next = rar_pkg::ST_DIV;
			end
			rar_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_next = rar_pkg::ST_WRITE;
				end
			end
			rar_pkg::ST_WRITE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_next   = rar_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = rar_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != rar_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/rar_dp.sv
`timescale 1ns / 1ps

module rar_dp #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic signed [OPERAND_WIDTH-1:0]       a_num,
	input  logic signed [OPERAND_WIDTH-1:0]       a_den,
	input  logic signed [OPERAND_WIDTH-1:0]       b_num,
	input  logic signed [OPERAND_WIDTH-1:0]       b_den,
	input  rar_pkg::cmd_t                         cmd,
	output rar_pkg::status_t                      status,
	output logic signed [rar_pkg::NUM_OUT_W-1:0]  sum_num,
	output logic        [rar_pkg::DEN_OUT_W-1:0]  sum_den
);

	localparam int W      = OPERAND_WIDTH;
	localparam int PW     = 2 * W;
	localparam int MW     = 2 * W + 1;
	localparam int KW     = $clog2(MW);
	localparam int CW     = $clog2(MW + 1);
	localparam int NEXT_W = (MW > rar_pkg::NUM_OUT_W) ? MW : rar_pkg::NUM_OUT_W;
	localparam int DEXT_W = (MW > rar_pkg::DEN_OUT_W) ? MW : rar_pkg::DEN_OUT_W;

	// operand magnitudes and signs
	logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
	logic          sa_q, sb_q;
	logic [W-1:0]  an_mag, ad_mag, bn_mag, bd_mag;
	logic          an_neg, ad_neg, bn_neg, bd_neg;

	// products and sum
	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] prod;
	logic [PW-1:0] t1_q, t2_q, den_q;
	logic [MW-1:0] mag_sum;
	logic          neg_sum;
	logic [MW-1:0] mag_q;
	logic          neg_q;
	logic          zero_q;

	// gcd
	logic [MW-1:0] x_q, y_q;
	logic [KW-1:0] k_q;

	// dividers for numerator and denominator share the divisor in x_q
	logic [MW-1:0] nq_q, dq_q, nr_q, dr_q;
	logic [CW-1:0] cnt_q;
	logic [MW:0]   n_part, d_part;
	logic          n_ge, d_ge;
	logic [MW:0]   n_diff, d_diff;

	logic [NEXT_W-1:0] num_ext;
	logic [DEXT_W-1:0] den_ext;
	logic signed [rar_pkg::NUM_OUT_W-1:0] sum_num_q;
	logic        [rar_pkg::DEN_OUT_W-1:0] sum_den_q;

	assign an_neg = a_num[W-1];
	assign bn_neg = b_num[W-1];
	assign an_mag = an_neg ? (~a_num + 1'b1) : a_num;
	assign bn_mag = bn_neg ? (~b_num + 1'b1) : b_num;

	// zero denominator counts as one
	always_comb begin
		if (a_den == '0) begin
			ad_mag = W'(1);
			ad_neg = 1'b0;
		end else begin
			ad_neg = a_den[W-1];
			ad_mag = ad_neg ? (~a_den + 1'b1) : a_den;
		end
		if (b_den == '0) begin
			bd_mag = W'(1);
			bd_neg = 1'b0;
		end else begin
			bd_neg = b_den[W-1];
			bd_mag = bd_neg ? (~b_den + 1'b1) : b_den;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			an_q <= an_mag;
			ad_q <= ad_mag;
			bn_q <= bn_mag;
			bd_q <= bd_mag;
			sa_q <= an_neg ^ ad_neg;
			sb_q <= bn_neg ^ bd_neg;
		end
	end

	// one shared multiplier computes the three products in turn
	always_comb begin
		case (cmd.mul_sel)
			rar_pkg::MUL_AN_BD: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
			rar_pkg::MUL_BN_AD: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			rar_pkg::MUL_AD_BD: begin
				mul_a = ad_q;
				mul_b = bd_q;
			end
			default: begin
				mul_a = an_q;
				mul_b = bd_q;
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				rar_pkg::MUL_AN_BD: t1_q  <= prod;
				rar_pkg::MUL_BN_AD: t2_q  <= prod;
				rar_pkg::MUL_AD_BD: den_q <= prod;
				default:            den_q <= prod;
			endcase
		end
	end

	always_comb begin
		if (sa_q == sb_q) begin
			mag_sum = MW'(t1_q) + MW'(t2_q);
			neg_sum = sa_q;
		end else if (t1_q >= t2_q) begin
			mag_sum = MW'(t1_q - t2_q);
			neg_sum = sa_q;
		end else begin
			mag_sum = MW'(t2_q - t1_q);
			neg_sum = sb_q;
		end
	end

	assign n_part = {nr_q, nq_q[MW-1]};
	assign d_part = {dr_q, dq_q[MW-1]};
	assign n_ge   = (n_part >= {1'b0, x_q});
	assign d_ge   = (d_part >= {1'b0, x_q});
	assign n_diff = n_part - {1'b0, x_q};
	assign d_diff = d_part - {1'b0, x_q};

	always_ff @(posedge clk) begin
		if (cmd.form_sum) begin
			mag_q  <= mag_sum;
			neg_q  <= neg_sum;
			zero_q <= (mag_sum == '0);
			x_q    <= mag_sum;
			y_q    <= MW'(den_q);
			k_q    <= '0;
		end else if (cmd.gcd_two) begin
			x_q <= x_q >> 1;
			y_q <= y_q >> 1;
			k_q <= k_q + 1'b1;
		end else if (cmd.gcd_odd) begin
			if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q > y_q) begin
				x_q <= (x_q - y_q) >> 1;
			end else begin
				y_q <= (y_q - x_q) >> 1;
			end
		end else if (cmd.scale) begin
			// restore the common power of two into the divisor
			x_q   <= x_q << k_q;
			nq_q  <= mag_q;
			dq_q  <= MW'(den_q);
			nr_q  <= '0;
			dr_q  <= '0;
			cnt_q <= CW'(MW);
		end else if (cmd.div_step) begin
			nr_q  <= n_ge ? n_diff[MW-1:0] : n_part[MW-1:0];
			dr_q  <= d_ge ? d_diff[MW-1:0] : d_part[MW-1:0];
			nq_q  <= {nq_q[MW-2:0], n_ge};
			dq_q  <= {dq_q[MW-2:0], d_ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign num_ext = neg_q ? (~NEXT_W'(nq_q) + 1'b1) : NEXT_W'(nq_q);
	assign den_ext = DEXT_W'(dq_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (zero_q) begin
				sum_num_q <= '0;
				sum_den_q <= rar_pkg::DEN_OUT_W'(1);
			end else begin
				sum_num_q <= num_ext[rar_pkg::NUM_OUT_W-1:0];
				sum_den_q <= den_ext[rar_pkg::DEN_OUT_W-1:0];
			end
		end
	end

	assign status.sum_zero  = zero_q;
	assign status.both_even = !x_q[0] && !y_q[0];
	assign status.gcd_eq    = (x_q == y_q);
	assign status.div_last  = (cnt_q == CW'(1));

	assign sum_num = sum_num_q;
	assign sum_den = sum_den_q;

endmodule

>>> rtl/rational_add_reduce_unit.sv
`timescale 1ns / 1ps
// Adds two signed fractions a_num/a_den + b_num/b_den and returns the sum in
// lowest terms with a positive denominator (zero denominators count as one,
// a zero sum comes out as 0/1). One item is worked on at a time: the three
// products on the shared multiplier, forming the sum, then a binary GCD that
// takes one shift or subtract step per cycle, forming the divisor, bit-serial
// division for numerator and denominator side by side, and the write into the
// output register. The time per item is set mainly by the GCD loop and the
// dividers; a zero sum skips both. A new item is taken once the previous one
// has moved into the output register.

`include "assert_macros.svh"

module rational_add_reduce_unit #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [OPERAND_WIDTH-1:0]       a_num,
	input  logic signed [OPERAND_WIDTH-1:0]       a_den,
	input  logic signed [OPERAND_WIDTH-1:0]       b_num,
	input  logic signed [OPERAND_WIDTH-1:0]       b_den,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [rar_pkg::NUM_OUT_W-1:0]  sum_num,
	output logic        [rar_pkg::DEN_OUT_W-1:0]  sum_den
);

	rar_pkg::cmd_t    cmd;
	rar_pkg::status_t status;

	rar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	rar_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk     (clk),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.cmd     (cmd),
		.status  (status),
		.sum_num (sum_num),
		.sum_den (sum_den)
	);

	// an accepted item keeps the input side closed on the next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// a result written to the output register is offered on the next cycle
	`ASSERT_NEXT(a_valid_after_load, clk, arst_n, cmd.out_load, out_valid)
	// iteration only runs while an item is inside the block
	`ASSERT_IMPLIES(a_iter_busy, clk, arst_n, cmd.gcd_two || cmd.gcd_odd || cmd.div_step, in_stall)

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int W = 16;
	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;

	typedef logic signed [W-1:0] operand_t;
	typedef logic signed [rar_pkg::NUM_OUT_W-1:0] num_t;
	typedef logic [rar_pkg::DEN_OUT_W-1:0] den_t;

	typedef struct packed {
		operand_t an;
		operand_t ad;
		operand_t bn;
		operand_t bd;
		logic     known;
		num_t     num;
		den_t     den;
	} sum_case_t;

	typedef struct packed {
		num_t num;
		den_t den;
	} fraction_t;

	// directed rows, expected value typed in only where it is obvious
	localparam int N_CASES = 20;
	localparam sum_case_t CASES [N_CASES] = '{
		'{0, 0, 0, 0, 1'b1, 0, 1},
		'{1, 0, 1, 0, 1'b1, 2, 1},
		'{1, 2, 1, 2, 1'b1, 1, 1},
		'{1, -2, 1, 2, 1'b1, 0, 1},
		'{-32768, 1, -32768, 1, 1'b1, -65536, 1},
		'{32767, 1, 32767, 1, 1'b1, 65534, 1},
		'{1, -32768, 1, -32768, 1'b1, -1, 16384},
		'{-32768, -32768, -32768, -32768, 1'b1, 2, 1},
		'{3, 6, -1, 2, 1'b1, 0, 1},
		'{1, 3, 1, 6, 1'b1, 1, 2},
		'{-1, -1, 0, 5, 1'b1, 1, 1},
		'{5, 0, -7, 0, 1'b1, -2, 1},
		'{1, -1, -1, 1, 1'b1, -2, 1},
		'{-32768, 0, 32767, -1, 1'b1, -65535, 1},
		'{0, -32768, 0, 32767, 1'b1, 0, 1},
		'{1, 32767, 1, -32768, 1'b0, 0, 0},
		'{32767, -32768, -32768, 32767, 1'b0, 0, 0},
		'{32767, 32767, -32767, 32766, 1'b0, 0, 0},
		'{1, 32767, 1, 32766, 1'b0, 0, 0},
		'{-32768, 32767, -32768, 32767, 1'b0, 0, 0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	operand_t a_num = '0;
	operand_t a_den = '0;
	operand_t b_num = '0;
	operand_t b_den = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	num_t sum_num;
	den_t sum_den;

	fraction_t pending_sums[$];
	fraction_t oldest_sum;
	int mismatch_count = 0;
	int cycle_count = 0;
	int idle_pct = 10;
	int stall_pct = 10;

	rational_add_reduce_unit #(
		.OPERAND_WIDTH(W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.a_num(a_num),
		.a_den(a_den),
		.b_num(b_num),
		.b_den(b_den),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sum_num(sum_num),
		.sum_den(sum_den)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sum of two fractions in lowest terms with a positive denominator
	function automatic fraction_t reduce_fraction_sum(input operand_t an, input operand_t ad,
			input operand_t bn, input operand_t bd);
		longint na, da, nb, db, top, bottom, x, y, r;
		fraction_t f;
		na = longint'(an);
		da = longint'(ad);
		nb = longint'(bn);
		db = longint'(bd);
		if (da == 0) begin
			da = 1;
		end
		if (db == 0) begin
			db = 1;
		end
		if (da < 0) begin
			da = -da;
			na = -na;
		end
		if (db < 0) begin
			db = -db;
			nb = -nb;
		end
		top = na * db + nb * da;
		bottom = da * db;
		if (top == 0) begin
			f.num = '0;
			f.den = den_t'(1);
			return f;
		end
		x = (top < 0) ? -top : top;
		y = bottom;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		top = top / x;
		bottom = bottom / x;
		f.num = top[rar_pkg::NUM_OUT_W-1:0];
		f.den = bottom[rar_pkg::DEN_OUT_W-1:0];
		return f;
	endfunction

	function automatic operand_t rand_operand();
		case ($urandom_range(5))
			0: return operand_t'($urandom_range(16) - 8);
			1: return '0;
			2: begin
				case ($urandom_range(3))
					0: return operand_t'(16'h8000);
					1: return operand_t'(16'h7fff);
					2: return operand_t'(-1);
					default: return operand_t'(1);
				endcase
			end
			3: return operand_t'(($urandom_range(1) ? -1 : 1) * (1 << $urandom_range(W - 1)));
			default: return operand_t'($urandom);
		endcase
	endfunction

	task automatic send_item(input sum_case_t c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_num <= c.an;
		a_den <= c.ad;
		b_num <= c.bn;
		b_den <= c.bd;
		do @(posedge clk); while (in_stall);
		if (c.known) begin
			pending_sums.push_back('{num: c.num, den: c.den});
		end else begin
			pending_sums.push_back(reduce_fraction_sum(c.an, c.ad, c.bn, c.bd));
		end
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_sums.size() == 0) begin
				$error("unexpected item: sum_num %0d sum_den %0d", sum_num, sum_den);
				mismatch_count++;
			end else begin
				oldest_sum = pending_sums.pop_front();
				if (sum_num !== oldest_sum.num) begin
					$error("sum_num: expected %0d, got %0d", oldest_sum.num, sum_num);
					mismatch_count++;
				end
				if (sum_den !== oldest_sum.den) begin
					$error("sum_den: expected %0d, got %0d", oldest_sum.den, sum_den);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		sum_case_t item;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_CASES; i++) begin
			send_item(CASES[i]);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// a long stretch with no gaps on either side
			idle_pct = (i >= 150 && i < 250) ? 0 : 10;
			stall_pct = idle_pct;
			if (i == 350) begin
				in_valid <= 1'b0;
				while (pending_sums.size() != 0) @(posedge clk);
			end
			item = '0;
			item.an = rand_operand();
			item.ad = rand_operand();
			item.bn = rand_operand();
			item.bd = rand_operand();
			// opposite fractions, so the sum cancels to zero (but -32768 negates to itself)
			if ($urandom_range(9) == 0) begin
				item.bn = -item.an;
				item.bd = item.ad;
			end
			send_item(item);
		end

		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/rar_pkg.sv
rtl/rar_ctrl.sv
rtl/rar_dp.sv
rtl/rational_add_reduce_unit.sv
test/tb.sv
